>>> hdl/smt_pkg.sv
package smt_pkg;

  // entry store and column table sizes
  localparam int ENTRY_DEPTH = 1024;
  localparam int EIDX_W      = 10;
  localparam int ETOT_W      = 11;
  localparam int COL_DEPTH   = 256;
  localparam int CIDX_W      = 8;
  localparam int ROW_W       = 8;
  localparam int RAWCOL_W    = 16;
  localparam int VAL_W       = 64;
  localparam int CNT_W       = 11;
  localparam int STORE_W     = VAL_W + CIDX_W + ROW_W;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 9;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 1'b1;

  // beat kinds
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FETCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam int IN_DATA_W  = ROW_W + RAWCOL_W + VAL_W;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 3;

  typedef enum logic [1:0] {
    RES_FULL  = 2'd0,
    RES_NONE  = 2'd1,
    RES_ENTRY = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic      take_load;
    logic      take_fetch;
    logic      take_clear;
    logic      ld_update;
    logic      ps_run;
    logic      sc_rd;
    logic      sc_cur;
    logic      sc_wr;
    logic      fe_ord;
    logic      fe_st;
    logic      fe_col;
    logic      out_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic emitting;
    logic ld_keep;
    logic ld_full;
    logic ps_done;
    logic sc_none;
    logic sc_last;
    logic fe_empty;
    logic out_free;
  } status_t;

endpackage

>>> hdl/sparse_matrix_transpose.sv
// Sparse matrix transpose by counting sort. Load beats (tuser 0) take
// (row, column, value) entries row by row; the column offset is subtracted,
// entries below it are dropped and an entry at or past the column count
// drops the rest of its row. A kept load does a count read-modify-write in
// the per-column count memory; a load into a full 1024-entry store returns
// one beat with store_full. The first fetch (tuser 1) after loading runs a
// prefix sweep over the 256 column counts and a scatter over the stored
// entries, one at a time through the store/cursor/order memory chain, then
// each fetch passes through the order, store and count memories and returns
// one transposed entry, column by column in input row order; with none left
// it returns a beat with none_left. Loads are ignored after the first fetch
// until a clear (tuser 2). Configuration is to be written by the user only
// while the block is idle; the block itself does not enforce this.
module sparse_matrix_transpose
  import smt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // stream in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // entry_row, entry_column, entry_value
  input  logic [KIND_W-1:0]     s_tuser,  // kind
  // stream out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // out_column, out_row, out_value, column_entries
  output logic [OUT_USER_W-1:0] m_tuser,  // last_of_all, none_left, store_full
  output logic                  m_tlast,  // last_of_column
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  smt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  smt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

>>> hdl/smt_ram.sv
module smt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read that holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/smt_ctrl.sv
module smt_ctrl
  import smt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic [KIND_W-1:0] s_tuser,
  output logic              s_tready,
  input  status_t           status,
  output cmd_t              cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_LD_UPD = 10'b0000000010,
    S_PS     = 10'b0000000100,
    S_SC_RD  = 10'b0000001000,
    S_SC_CUR = 10'b0000010000,
    S_SC_WR  = 10'b0000100000,
    S_FE_CHK = 10'b0001000000,
    S_FE_ST  = 10'b0010000000,
    S_FE_COL = 10'b0100000000,
    S_RESULT = 10'b1000000000
  } state_t;

  state_t    state, state_next;
  res_kind_t res, res_next;
  logic      accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // state and pending result kind
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= RES_NONE;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  // sequencing
  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    cmd.res_kind = res;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_tuser)
            KIND_LOAD: begin
              cmd.take_load = 1'b1;
              if (status.ld_full) begin
                res_next   = RES_FULL;
                state_next = S_RESULT;
              end else if (status.ld_keep) begin
                state_next = S_LD_UPD;
              end
            end
            KIND_FETCH: begin
              cmd.take_fetch = 1'b1;
              state_next = status.emitting ? S_FE_CHK : S_PS;
            end
            KIND_CLEAR: begin
              cmd.take_clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_LD_UPD: begin
        cmd.ld_update = 1'b1;
        state_next    = S_IDLE;
      end
      S_PS: begin
        cmd.ps_run = 1'b1;
        if (status.ps_done) begin
          state_next = status.sc_none ? S_FE_CHK : S_SC_RD;
        end
      end
      S_SC_RD: begin
        cmd.sc_rd  = 1'b1;
        state_next = S_SC_CUR;
      end
      S_SC_CUR: begin
        cmd.sc_cur = 1'b1;
        state_next = S_SC_WR;
      end
      S_SC_WR: begin
        cmd.sc_wr  = 1'b1;
        state_next = status.sc_last ? S_FE_CHK : S_SC_RD;
      end
      S_FE_CHK: begin
        if (status.fe_empty) begin
          res_next   = RES_NONE;
          state_next = S_RESULT;
        end else begin
          cmd.fe_ord = 1'b1;
          state_next = S_FE_ST;
        end
      end
      S_FE_ST: begin
        cmd.fe_st  = 1'b1;
        state_next = S_FE_COL;
      end
      S_FE_COL: begin
        cmd.fe_col = 1'b1;
        res_next   = RES_ENTRY;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/smt_dp.sv
module smt_dp
  import smt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast
);

  logic [COUNT_W-1:0]    column_count;
  logic [RAWCOL_W-1:0]   column_offset;
  logic [ETOT_W-1:0]     entry_total;
  logic                  skipping;
  logic [ROW_W-1:0]      current_row;
  logic                  emitting;
  logic [ETOT_W-1:0]     fetch_pos;
  logic [COL_DEPTH-1:0]  cnt_valid;
  logic [CIDX_W-1:0]     cnt_raddr_q;
  logic [CIDX_W:0]       ps_idx;
  logic                  ps_pend;
  logic [CIDX_W-1:0]     ps_addr_q;
  logic [CNT_W-1:0]      sum;
  logic [EIDX_W-1:0]     sc_i;

  logic [ROW_W-1:0]      in_row;
  logic [RAWCOL_W-1:0]   in_col;
  logic [VAL_W-1:0]      in_val;
  logic [RAWCOL_W:0]     diff;
  logic                  neg, out_range, eff_skip;
  logic [COUNT_W-1:0]    limit;

  logic [STORE_W-1:0]    st_rdata;
  logic                  st_re;
  logic [EIDX_W-1:0]     st_raddr;
  logic [CIDX_W-1:0]     st_col;
  logic [ROW_W-1:0]      st_row;
  logic [VAL_W-1:0]      st_val;

  logic [CNT_W-1:0]      cnt_rdata, cnt_val;
  logic                  cnt_re;
  logic [CIDX_W-1:0]     cnt_raddr;

  logic [CNT_W-1:0]      cur_rdata, cur_wdata;
  logic                  cur_we;
  logic [CIDX_W-1:0]     cur_waddr;

  logic [EIDX_W-1:0]     ord_rdata;
  logic [ETOT_W-1:0]     fetch_pos_inc;

  // input beat fields
  assign in_row = s_tdata[ROW_W-1:0];
  assign in_col = s_tdata[ROW_W +: RAWCOL_W];
  assign in_val = s_tdata[ROW_W+RAWCOL_W +: VAL_W];

  // load screening
  assign diff      = {1'b0, in_col} - {1'b0, column_offset};
  assign neg       = diff[RAWCOL_W];
  assign limit     = (column_count > COUNT_W'(COL_DEPTH)) ? COUNT_W'(COL_DEPTH) : column_count;
  assign out_range = !neg && (diff[RAWCOL_W-1:0] >= RAWCOL_W'(limit));
  assign eff_skip  = (in_row == current_row) && skipping;

  assign status.emitting = emitting;
  assign status.ld_keep  = !emitting && !eff_skip && !neg && !out_range &&
                           !entry_total[ETOT_W-1];
  assign status.ld_full  = !emitting && !eff_skip && !neg && !out_range &&
                           entry_total[ETOT_W-1];
  assign status.ps_done  = ps_idx[CIDX_W] && !ps_pend;
  assign status.sc_none  = (entry_total == '0);
  assign status.sc_last  = ({1'b0, sc_i} + ETOT_W'(1)) == entry_total;
  assign status.fe_empty = (fetch_pos >= entry_total);
  assign status.out_free = !m_tvalid || m_tready;

  assign st_row  = st_rdata[ROW_W-1:0];
  assign st_col  = st_rdata[ROW_W +: CIDX_W];
  assign st_val  = st_rdata[ROW_W+CIDX_W +: VAL_W];
  assign cnt_val = cnt_valid[cnt_raddr_q] ? cnt_rdata : '0;
  assign fetch_pos_inc = fetch_pos + ETOT_W'(1);

  // memory port selection
  assign st_re     = cmd.sc_rd || cmd.fe_st;
  assign st_raddr  = cmd.sc_rd ? sc_i : ord_rdata;
  assign cnt_re    = (cmd.take_load && status.ld_keep) ||
                     (cmd.ps_run && !ps_idx[CIDX_W]) || cmd.fe_col;
  assign cnt_raddr = cmd.take_load ? diff[CIDX_W-1:0] :
                     cmd.ps_run    ? ps_idx[CIDX_W-1:0] : st_col;
  assign cur_we    = (cmd.ps_run && ps_pend) || cmd.sc_wr;
  assign cur_waddr = cmd.sc_wr ? st_col : ps_addr_q;
  assign cur_wdata = cmd.sc_wr ? cur_rdata + CNT_W'(1) : sum;

  smt_ram #(.WIDTH(STORE_W), .DEPTH(ENTRY_DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.take_load && status.ld_keep),
    .waddr (entry_total[EIDX_W-1:0]),
    .wdata ({in_val, diff[CIDX_W-1:0], in_row}),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  smt_ram #(.WIDTH(CNT_W), .DEPTH(COL_DEPTH)) u_count (
    .clk   (clk),
    .we    (cmd.ld_update),
    .waddr (cnt_raddr_q),
    .wdata (cnt_val + CNT_W'(1)),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  smt_ram #(.WIDTH(CNT_W), .DEPTH(COL_DEPTH)) u_cursor (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .re    (cmd.sc_cur || cmd.fe_col),
    .raddr (st_col),
    .rdata (cur_rdata)
  );

  smt_ram #(.WIDTH(EIDX_W), .DEPTH(ENTRY_DEPTH)) u_order (
    .clk   (clk),
    .we    (cmd.sc_wr),
    .waddr (cur_rdata[EIDX_W-1:0]),
    .wdata (sc_i),
    .re    (cmd.fe_ord),
    .raddr (fetch_pos[EIDX_W-1:0]),
    .rdata (ord_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= COUNT_W'(COL_DEPTH);
      column_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_COUNT:  column_count  <= cfg_data[COUNT_W-1:0];
        REG_COLUMN_OFFSET: column_offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // matrix bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_total <= '0;
      skipping    <= 1'b0;
      current_row <= '0;
      emitting    <= 1'b0;
      fetch_pos   <= '0;
      cnt_valid   <= '0;
      ps_idx      <= '0;
      ps_pend     <= 1'b0;
      sum         <= '0;
      sc_i        <= '0;
    end else begin
      if (cmd.take_clear) begin
        entry_total <= '0;
        skipping    <= 1'b0;
        current_row <= '0;
        emitting    <= 1'b0;
        fetch_pos   <= '0;
        cnt_valid   <= '0;
      end
      if (cmd.take_load && !emitting) begin
        current_row <= in_row;
        skipping    <= eff_skip || (!neg && out_range);
        if (status.ld_keep) begin
          entry_total <= entry_total + ETOT_W'(1);
        end
      end
      if (cmd.ld_update) begin
        cnt_valid[cnt_raddr_q] <= 1'b1;
      end
      if (cmd.take_fetch && !emitting) begin
        emitting  <= 1'b1;
        fetch_pos <= '0;
        ps_idx    <= '0;
        ps_pend   <= 1'b0;
        sum       <= '0;
        sc_i      <= '0;
      end
      // prefix sweep: read a count, write the start cursor in the next cycle
      if (cmd.ps_run) begin
        ps_pend <= !ps_idx[CIDX_W];
        if (!ps_idx[CIDX_W]) begin
          ps_idx <= ps_idx + (CIDX_W+1)'(1);
        end
        if (ps_pend) begin
          sum <= sum + cnt_val;
        end
      end
      if (cmd.sc_wr) begin
        sc_i <= sc_i + EIDX_W'(1);
      end
      if (cmd.out_load && (cmd.res_kind == RES_ENTRY)) begin
        fetch_pos <= fetch_pos_inc;
      end
    end
  end

  // read address trail for valid lookup and cursor write
  always_ff @(posedge clk) begin
    if (cnt_re) begin
      cnt_raddr_q <= cnt_raddr;
    end
    ps_addr_q <= ps_idx[CIDX_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= '0;
      m_tuser <= '0;
      m_tlast <= 1'b0;
      case (cmd.res_kind)
        RES_FULL: m_tuser[2] <= 1'b1;
        RES_NONE: m_tuser[1] <= 1'b1;
        RES_ENTRY: begin
          m_tdata <= {5'b0, cnt_val, st_val, st_row, st_col};
          m_tlast <= (fetch_pos_inc == cur_rdata);
          m_tuser[0] <= (fetch_pos_inc == entry_total);
        end
        default: begin
        end
      endcase
    end
  end

endmodule
